@@ hw/rtl/radix_integer_to_ascii_defines.svh @@
// Assertion macros for the radix integer to ASCII converter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef RADIX_INTEGER_TO_ASCII_DEFINES_SVH
`define RADIX_INTEGER_TO_ASCII_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RITOA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ritoa_pkg.sv @@
// Shared constants, types and functions of the radix integer to ASCII converter.
// No dependencies.
package ritoa_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 32;
  localparam int DIG_AW     = $clog2(MAX_DIGITS);
  localparam int DIV_CW     = $clog2(VALUE_BITS);
  localparam int RADIX_W    = 6;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] TOP_DIGIT   = 6'd35;
  localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_LOWA   = 8'h61;
  localparam logic [7:0] CHAR_INVALID = 8'h00;

  localparam logic REG_RADIX = 1'b0;

  typedef logic [RADIX_W-1:0] radix_t;

  typedef struct packed {
    logic                  bad;
    logic [VALUE_BITS-1:0] number;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] dc;
    dc = (d > TOP_DIGIT) ? TOP_DIGIT : d;
    if (dc < DEC_DIGITS) begin
      return ASCII_ZERO + 8'(dc);
    end
    return ASCII_LOWA + 8'(dc - DEC_DIGITS);
  endfunction

endpackage

@@ hw/rtl/radix_integer_to_ascii.sv @@
// Top level of the radix integer to ASCII converter: radix register, front end, back end.
// Depends on ritoa_pkg, ritoa_front, ritoa_back and radix_integer_to_ascii_defines.svh.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | in_push / in_full  | in_number
//  result   | out_pop / out_empty| out_char_code, out_last_char, out_bad_radix
//  config   | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// Each digit is computed in the bit-serial divider and each character is read back
// from the digit store; an item gives up to 32 digits, and the next item waits for idle.
// A bad radix gives its single result once the item is taken and the result register is free.
// Reset is synchronous on rst_n; it sets radix to 10 and empties both sides.
// The front queue holds two items; the result register waits on out_pop.
`include "radix_integer_to_ascii_defines.svh"
module radix_integer_to_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [ritoa_pkg::VALUE_BITS-1:0] in_number,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_char_code,
  output logic        out_last_char,
  output logic        out_bad_radix,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ritoa_pkg::*;

  radix_t     radix_r, radix_nxt;
  logic       q_empty;
  logic       q_pop;
  job_t       q_job;
  logic       cfg_wr;
  logic       out_bad_vld;
  logic       out_is_digit;
  logic       out_wait;
  logic [9:0] out_word;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RADIX);
  assign prdata = (paddr[2] == REG_RADIX) ? 32'(radix_r) : '0;

  always_comb begin
    radix_nxt = cfg_wr ? pwdata[RADIX_W-1:0] : radix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  ritoa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .radix     (radix_r),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_number (in_number),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_job     (q_job)
  );

  ritoa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .radix         (radix_r),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_job         (q_job),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char),
    .out_bad_radix (out_bad_radix)
  );

  assign out_bad_vld  = !out_empty && out_bad_radix;
  assign out_is_digit = ((out_char_code >= 8'h30) && (out_char_code <= 8'h39)) ||
                        ((out_char_code >= 8'h61) && (out_char_code <= 8'h7a));
  assign out_wait     = !out_empty && !out_pop;
  assign out_word     = {out_char_code, out_last_char, out_bad_radix};

  `RITOA_ASSERT_NOW(a_bad_is_last, out_bad_vld, out_last_char, "bad radix item not last")
  `RITOA_ASSERT_NOW(a_bad_is_nul, out_bad_vld, out_char_code == CHAR_INVALID, "bad radix not NUL")
  `RITOA_ASSERT_NOW(a_char_range, !out_empty && !out_bad_radix, out_is_digit, "char not a digit")
  `RITOA_ASSERT_NEXT(a_out_hold, out_wait, !out_empty && $stable(out_word), "waiting item changed")

endmodule

@@ hw/rtl/ritoa_front.sv @@
// Front end: accepts items, flags a bad radix, holds them in a two-entry queue.
// Depends on ritoa_pkg.
module ritoa_front (
  input  logic              clk,
  input  logic              rst_n,
  input  ritoa_pkg::radix_t radix,
  input  logic              in_push,
  output logic              in_full,
  input  logic [ritoa_pkg::VALUE_BITS-1:0] in_number,
  output logic              q_empty,
  input  logic              q_pop,
  output ritoa_pkg::job_t   q_job
);
  import ritoa_pkg::*;

  job_t       q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok, pop_ok;
  job_t       new_job;

  assign in_full = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_job   = q_mem[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && !q_empty;

  always_comb begin
    new_job.bad    = (radix < RADIX_MIN) || (radix > RADIX_MAX);
    new_job.number = in_number;
    wr_ptr_nxt     = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt     = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt        = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem[wr_ptr_r] <= new_job;
    end
  end

endmodule

@@ hw/rtl/ritoa_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ritoa_pkg.
module ritoa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ritoa_pkg::VALUE_BITS-1:0] dividend,
  input  ritoa_pkg::radix_t divisor,
  output logic              done,
  output logic [ritoa_pkg::VALUE_BITS-1:0] quot,
  output ritoa_pkg::radix_t rem
);
  import ritoa_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CW-1:0]     cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] qr_r, qr_nxt;
  radix_t                rem_r, rem_nxt;
  radix_t                div_r, div_nxt;
  logic [RADIX_W:0]      rem_sh;
  logic                  ge;

  assign done = done_r;
  assign quot = qr_r;
  assign rem  = rem_r;

  always_comb begin
    rem_sh   = {rem_r, qr_r[VALUE_BITS-1]};
    ge       = rem_sh >= {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    qr_nxt   = qr_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CW'(VALUE_BITS - 1);
      qr_nxt   = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      qr_nxt  = {qr_r[VALUE_BITS-2:0], ge};
      rem_nxt = ge ? RADIX_W'(rem_sh - {1'b0, div_r}) : RADIX_W'(rem_sh);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qr_r  <= qr_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

endmodule

@@ hw/rtl/ritoa_back.sv @@
// Back end: digit loop over the serial divider, digit store, reverse readout
// into the result register. Depends on ritoa_pkg and ritoa_div.
module ritoa_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ritoa_pkg::radix_t radix,
  input  logic              q_empty,
  output logic              q_pop,
  input  ritoa_pkg::job_t   q_job,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_char_code,
  output logic              out_last_char,
  output logic              out_bad_radix
);
  import ritoa_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_PUT  = 3'd3;
  localparam logic [2:0] ST_BAD  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [DIG_AW-1:0]     idx_r, idx_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [7:0]            char_r, char_nxt;
  logic                  last_r, last_nxt;
  logic                  bad_r, bad_nxt;
  logic [RADIX_W-1:0]    store_mem [MAX_DIGITS];
  logic [RADIX_W-1:0]    rd_data_r;
  logic                  wr_en;
  logic                  slot_free;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  radix_t                div_rem;

  ritoa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (radix),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign slot_free     = !out_vld_r || out_pop;
  assign out_empty     = !out_vld_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;
  assign out_bad_radix = bad_r;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    out_vld_nxt  = out_pop ? 1'b0 : out_vld_r;
    char_nxt     = char_r;
    last_nxt     = last_r;
    bad_nxt      = bad_r;
    q_pop        = 1'b0;
    wr_en        = 1'b0;
    div_start    = 1'b0;
    div_dividend = q_job.number;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_job.bad) begin
            state_nxt = ST_BAD;
          end else begin
            div_start = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        div_dividend = div_quot;
        if (div_done) begin
          wr_en = 1'b1;
          if ((div_quot != '0) && (idx_r != DIG_AW'(MAX_DIGITS - 1))) begin
            idx_nxt   = idx_r + 1'b1;
            div_start = 1'b1;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (slot_free) begin
          out_vld_nxt = 1'b1;
          char_nxt    = digit_char(rd_data_r);
          last_nxt    = (idx_r == '0);
          bad_nxt     = 1'b0;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_BAD: begin
        if (slot_free) begin
          out_vld_nxt = 1'b1;
          char_nxt    = CHAR_INVALID;
          last_nxt    = 1'b1;
          bad_nxt     = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
  end

  // digit store, least significant digit at index 0
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[idx_r] <= div_rem;
    end
    rd_data_r <= store_mem[idx_r];
  end

endmodule
